// ----- hdl/voxel_sphere_paint_macros.svh -----
// Assertion macros shared by the voxel sphere paint modules.
`ifndef VOXEL_SPHERE_PAINT_MACROS_SVH
`define VOXEL_SPHERE_PAINT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define VSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define VSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vsp_pkg.sv -----
// Shared constants, types and helper functions of the voxel sphere paint block.
`default_nettype none

package vsp_pkg;

    // Volume geometry and radius limit
    localparam int DIM_X      = 64;
    localparam int DIM_Y      = 64;
    localparam int DIM_Z      = 64;
    localparam int MAX_RADIUS = 15;

    localparam int VOXEL_COUNT = DIM_X * DIM_Y * DIM_Z;
    localparam int ADDR_W      = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;

    // Field widths
    localparam int POS_W    = 6;
    localparam int LEVEL_W  = 16;
    localparam int SIZE_W   = 7;
    localparam int RADREG_W = 4;
    localparam int COUNT_W  = 15;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Offset and distance widths
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int OFF_W   = RAD_W + 1;
    localparam int COORD_W = 8;
    localparam int SQ_W    = 2 * OFF_W;
    localparam int DIST_W  = SQ_W + 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PAINT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0]          RST_SIZE       = 7'd64;
    localparam logic [RADREG_W-1:0]        RST_RADIUS     = 4'd5;
    localparam logic signed [LEVEL_W-1:0]  RST_BACKGROUND = -16'sd1024;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic load_wr;
        logic paint_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic walk_last;
    } t_dp_status;

    // Extent register capped at the volume dimension
    function automatic logic [SIZE_W-1:0] extent_of(input logic [SIZE_W-1:0] size,
                                                    input int dim);
        if (int'(size) > dim) begin
            return SIZE_W'(dim);
        end
        return size;
    endfunction

    // Radius register capped at the radius limit
    function automatic logic [RAD_W-1:0] eff_radius(input logic [RADREG_W-1:0] radius);
        if (int'(radius) > MAX_RADIUS) begin
            return RAD_W'(MAX_RADIUS);
        end
        return RAD_W'(radius);
    endfunction

    // Coordinate lies in 0 .. ext-1
    function automatic logic coord_inside(input logic signed [COORD_W-1:0] c,
                                          input logic [SIZE_W-1:0] ext);
        return !c[COORD_W-1] && (c[COORD_W-2:0] < ext);
    endfunction

    // Linear address of an in-volume voxel, x fastest
    function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-2:0] x,
                                                  input logic [COORD_W-2:0] y,
                                                  input logic [COORD_W-2:0] z);
        return ADDR_W'(x) + ADDR_W'(DIM_X) * (ADDR_W'(y) + ADDR_W'(DIM_Y) * ADDR_W'(z));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vsp_if.sv -----
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none

interface vsp_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [vsp_pkg::ACT_W-1:0]             action;
    logic [vsp_pkg::POS_W-1:0]             pos_x;
    logic [vsp_pkg::POS_W-1:0]             pos_y;
    logic [vsp_pkg::POS_W-1:0]             pos_z;
    logic signed [vsp_pkg::LEVEL_W-1:0]    level;

    modport source (output valid, action, pos_x, pos_y, pos_z, level, input ready);
    modport sink   (input valid, action, pos_x, pos_y, pos_z, level, output ready);
endinterface

interface vsp_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vsp_pkg::LEVEL_W-1:0]    read_level;
    logic [vsp_pkg::COUNT_W-1:0]           changed_count;

    modport source (output valid, read_level, changed_count, input ready);
    modport sink   (input valid, read_level, changed_count, output ready);
endinterface

interface vsp_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [vsp_pkg::CFG_IDX_W-1:0]         index;
    logic [vsp_pkg::LEVEL_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/voxel_sphere_paint.sv -----
// Voxel sphere paint block: a 3-D voxel store that loads, reads back and
// paints spheres. Each item is taken on the in channel and yields one result
// on the out channel. A load or read passes through its own state to the
// finish state, which loads the result register; an unused action goes
// straight to the finish state. A paint does a single read-modify-write of
// the voxel memory per offset of the cube of side 2r+1, r being the sphere
// radius capped at the radius limit, then a drain state retires the last
// write. The next item is taken in the cycle after the result register
// loads; a result held off by the receiver stalls the block until it
// transfers. A finished result waits in its register while the next item is
// taken. The voxel memory is not cleared at reset: read or paint only voxels
// that were loaded. Write configuration only while no item is in progress.
`default_nettype none

module voxel_sphere_paint (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vsp_in_if.sink    i_in,
    vsp_out_if.source o_out,
    vsp_cfg_if.sink   i_cfg
);

    vsp_pkg::t_dp_cmd    w_cmd;
    vsp_pkg::t_dp_status w_status;
    logic                w_in_ready;
    logic                w_out_valid;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    vsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    vsp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_action        (i_in.action),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_pos_z         (i_in.pos_z),
        .i_level         (i_in.level),
        .o_read_level    (o_out.read_level),
        .o_changed_count (o_out.changed_count)
    );

endmodule

`default_nettype wire

// ----- hdl/vsp_ctrl.sv -----
// Controller state machine: sequences load, read and paint items.
`default_nettype none
`include "voxel_sphere_paint_macros.svh"

module vsp_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [vsp_pkg::ACT_W-1:0] i_action,
    output logic                           o_in_ready,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    input  wire vsp_pkg::t_dp_status       i_status,
    output vsp_pkg::t_dp_cmd               o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_PAINT,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode commands from the state
    always_comb begin
        o_cmd            = '0;
        o_cmd.start      = o_in_ready && i_in_valid;
        o_cmd.load_wr    = (r_state == S_LOAD);
        o_cmd.paint_step = (r_state == S_PAINT);
        o_cmd.out_load   = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    // Next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    case (i_action)
                        vsp_pkg::ACT_LOAD:  n_state = S_LOAD;
                        vsp_pkg::ACT_READ:  n_state = S_READ;
                        vsp_pkg::ACT_PAINT: n_state = S_PAINT;
                        default:            n_state = S_FINISH;
                    endcase
                end
            end
            S_LOAD:  n_state = S_FINISH;
            S_READ:  n_state = S_FINISH;
            S_PAINT: begin
                if (i_status.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_FINISH;
            S_FINISH: begin
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `VSP_ASSERT_NEXT(a_walk_end, (r_state == S_PAINT) && i_status.walk_last, r_state == S_DRAIN, "paint walk did not end in drain")
    `VSP_ASSERT_NOW(a_no_overwrite, o_cmd.out_load, !r_out_valid || i_out_ready, "result register overwritten before transfer")
    `VSP_ASSERT_NEXT(a_paint_start, o_cmd.start && (i_action == vsp_pkg::ACT_PAINT), r_state == S_PAINT, "paint item did not enter the walk")

endmodule

`default_nettype wire

// ----- hdl/vsp_datapath.sv -----
// Datapath: configuration registers, voxel memory, offset walk and result register.
`default_nettype none
`include "voxel_sphere_paint_macros.svh"

module vsp_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire vsp_pkg::t_dp_cmd                   i_cmd,
    output vsp_pkg::t_dp_status                     o_status,
    input  wire logic                               i_cfg_wr,
    input  wire logic [vsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [vsp_pkg::LEVEL_W-1:0]        i_cfg_data,
    input  wire logic [vsp_pkg::ACT_W-1:0]          i_action,
    input  wire logic [vsp_pkg::POS_W-1:0]          i_pos_x,
    input  wire logic [vsp_pkg::POS_W-1:0]          i_pos_y,
    input  wire logic [vsp_pkg::POS_W-1:0]          i_pos_z,
    input  wire logic signed [vsp_pkg::LEVEL_W-1:0] i_level,
    output logic signed [vsp_pkg::LEVEL_W-1:0]      o_read_level,
    output logic [vsp_pkg::COUNT_W-1:0]             o_changed_count
);

    localparam int COORD_W = vsp_pkg::COORD_W;
    localparam int OFF_W   = vsp_pkg::OFF_W;
    localparam int SQ_W    = vsp_pkg::SQ_W;
    localparam int DIST_W  = vsp_pkg::DIST_W;
    localparam int ADDR_W  = vsp_pkg::ADDR_W;
    localparam int LEVEL_W = vsp_pkg::LEVEL_W;

    // Configuration registers
    logic [vsp_pkg::SIZE_W-1:0]   r_size_x;
    logic [vsp_pkg::SIZE_W-1:0]   r_size_y;
    logic [vsp_pkg::SIZE_W-1:0]   r_size_z;
    logic [vsp_pkg::RADREG_W-1:0] r_radius;
    logic [LEVEL_W-1:0]           r_bg;

    // Item registers
    logic [vsp_pkg::ACT_W-1:0] r_act;
    logic [vsp_pkg::POS_W-1:0] r_pos_x;
    logic [vsp_pkg::POS_W-1:0] r_pos_y;
    logic [vsp_pkg::POS_W-1:0] r_pos_z;
    logic [LEVEL_W-1:0]        r_level;

    // Walk and write-back stage
    logic signed [OFF_W-1:0] r_off_i;
    logic signed [OFF_W-1:0] r_off_j;
    logic signed [OFF_W-1:0] r_off_k;
    logic                    r_s1_valid;
    logic                    r_s1_hit;
    logic [ADDR_W-1:0]       r_s1_addr;
    logic [vsp_pkg::COUNT_W-1:0] r_count;

    // Memory and result registers
    logic [LEVEL_W-1:0]         r_mem [vsp_pkg::VOXEL_COUNT];
    logic [LEVEL_W-1:0]         r_rd_data;
    logic signed [LEVEL_W-1:0]  r_out_read_level;
    logic [vsp_pkg::COUNT_W-1:0] r_out_changed;

    logic [vsp_pkg::SIZE_W-1:0] w_ext_x;
    logic [vsp_pkg::SIZE_W-1:0] w_ext_y;
    logic [vsp_pkg::SIZE_W-1:0] w_ext_z;
    logic [vsp_pkg::RAD_W-1:0]  w_r_eff;
    logic signed [OFF_W-1:0]    w_pos_r;
    logic signed [OFF_W-1:0]    w_neg_r;
    logic signed [COORD_W-1:0]  w_cmd_x;
    logic signed [COORD_W-1:0]  w_cmd_y;
    logic signed [COORD_W-1:0]  w_cmd_z;
    logic                       w_cmd_inside;
    logic [ADDR_W-1:0]          w_cmd_addr;
    logic signed [COORD_W-1:0]  w_cx;
    logic signed [COORD_W-1:0]  w_cy;
    logic signed [COORD_W-1:0]  w_cz;
    logic [SQ_W-1:0]            w_sq_i;
    logic [SQ_W-1:0]            w_sq_j;
    logic [SQ_W-1:0]            w_sq_k;
    logic [SQ_W-1:0]            w_r2;
    logic [DIST_W-1:0]          w_dist;
    logic                       w_walk_hit;
    logic [ADDR_W-1:0]          w_walk_addr;
    logic [ADDR_W-1:0]          w_rd_addr;
    logic                       w_paint_wr;
    logic                       w_load_wr;
    logic                       w_wr_en;
    logic [ADDR_W-1:0]          w_wr_addr;
    logic [LEVEL_W-1:0]         w_wr_data;

    // Effective extents and radius
    assign w_ext_x = vsp_pkg::extent_of(r_size_x, vsp_pkg::DIM_X);
    assign w_ext_y = vsp_pkg::extent_of(r_size_y, vsp_pkg::DIM_Y);
    assign w_ext_z = vsp_pkg::extent_of(r_size_z, vsp_pkg::DIM_Z);
    assign w_r_eff = vsp_pkg::eff_radius(r_radius);
    assign w_pos_r = $signed({1'b0, w_r_eff});
    assign w_neg_r = -w_pos_r;

    // Item voxel position and address
    assign w_cmd_x      = $signed(COORD_W'(r_pos_x));
    assign w_cmd_y      = $signed(COORD_W'(r_pos_y));
    assign w_cmd_z      = $signed(COORD_W'(r_pos_z));
    assign w_cmd_inside = vsp_pkg::coord_inside(w_cmd_x, w_ext_x)
                       && vsp_pkg::coord_inside(w_cmd_y, w_ext_y)
                       && vsp_pkg::coord_inside(w_cmd_z, w_ext_z);
    assign w_cmd_addr   = vsp_pkg::addr_of(w_cmd_x[COORD_W-2:0], w_cmd_y[COORD_W-2:0],
                                           w_cmd_z[COORD_W-2:0]);

    // Walk voxel position, distance test and address
    assign w_cx   = w_cmd_x + COORD_W'(r_off_i);
    assign w_cy   = w_cmd_y + COORD_W'(r_off_j);
    assign w_cz   = w_cmd_z + COORD_W'(r_off_k);
    assign w_sq_i = SQ_W'(SQ_W'(r_off_i) * SQ_W'(r_off_i));
    assign w_sq_j = SQ_W'(SQ_W'(r_off_j) * SQ_W'(r_off_j));
    assign w_sq_k = SQ_W'(SQ_W'(r_off_k) * SQ_W'(r_off_k));
    assign w_r2   = SQ_W'(SQ_W'(w_r_eff) * SQ_W'(w_r_eff));
    assign w_dist = DIST_W'(w_sq_i) + DIST_W'(w_sq_j) + DIST_W'(w_sq_k);
    assign w_walk_hit = (w_dist <= DIST_W'(w_r2))
                     && vsp_pkg::coord_inside(w_cx, w_ext_x)
                     && vsp_pkg::coord_inside(w_cy, w_ext_y)
                     && vsp_pkg::coord_inside(w_cz, w_ext_z);
    assign w_walk_addr = vsp_pkg::addr_of(w_cx[COORD_W-2:0], w_cy[COORD_W-2:0],
                                          w_cz[COORD_W-2:0]);

    assign o_status.walk_last = (r_off_i == w_pos_r) && (r_off_j == w_pos_r)
                             && (r_off_k == w_pos_r);

    // Memory port selection
    assign w_rd_addr  = i_cmd.paint_step ? w_walk_addr : w_cmd_addr;
    assign w_paint_wr = r_s1_valid && r_s1_hit && (r_rd_data != r_bg);
    assign w_load_wr  = i_cmd.load_wr && w_cmd_inside;
    assign w_wr_en    = w_paint_wr || w_load_wr;
    assign w_wr_addr  = w_paint_wr ? r_s1_addr : w_cmd_addr;
    assign w_wr_data  = r_level;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= vsp_pkg::RST_SIZE;
            r_size_y <= vsp_pkg::RST_SIZE;
            r_size_z <= vsp_pkg::RST_SIZE;
            r_radius <= vsp_pkg::RST_RADIUS;
            r_bg     <= vsp_pkg::RST_BACKGROUND;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                vsp_pkg::CFG_SIZE_X:     r_size_x <= i_cfg_data[vsp_pkg::SIZE_W-1:0];
                vsp_pkg::CFG_SIZE_Y:     r_size_y <= i_cfg_data[vsp_pkg::SIZE_W-1:0];
                vsp_pkg::CFG_SIZE_Z:     r_size_z <= i_cfg_data[vsp_pkg::SIZE_W-1:0];
                vsp_pkg::CFG_RADIUS:     r_radius <= i_cfg_data[vsp_pkg::RADREG_W-1:0];
                vsp_pkg::CFG_BACKGROUND: r_bg     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act   <= i_action;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
            r_level <= i_level;
        end
    end

    // Advance the offset walk, x fastest
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_off_i <= w_neg_r;
            r_off_j <= w_neg_r;
            r_off_k <= w_neg_r;
        end else if (i_cmd.paint_step) begin
            if (r_off_i == w_pos_r) begin
                r_off_i <= w_neg_r;
                if (r_off_j == w_pos_r) begin
                    r_off_j <= w_neg_r;
                    r_off_k <= r_off_k + OFF_W'(1);
                end else begin
                    r_off_j <= r_off_j + OFF_W'(1);
                end
            end else begin
                r_off_i <= r_off_i + OFF_W'(1);
            end
        end
    end

    // Write-back stage: valid flag and changed counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_count    <= '0;
        end else begin
            r_s1_valid <= i_cmd.paint_step;
            if (i_cmd.start) begin
                r_count <= '0;
            end else if (w_paint_wr) begin
                r_count <= r_count + vsp_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit  <= w_walk_hit;
        r_s1_addr <= w_walk_addr;
    end

    // Voxel memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_read_level <= ((r_act == vsp_pkg::ACT_READ) && w_cmd_inside)
                              ? $signed(r_rd_data) : '0;
            r_out_changed    <= (r_act == vsp_pkg::ACT_PAINT) ? r_count : '0;
        end
    end

    assign o_read_level    = r_out_read_level;
    assign o_changed_count = r_out_changed;

    `VSP_ASSERT_NOW(a_walk_range, i_cmd.paint_step, (r_off_k <= w_pos_r) && (r_off_k >= w_neg_r), "walk offset left the cube")

endmodule

`default_nettype wire
